[rtl/pls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_pkg
// shared constants, codes and types of the pov lap sync pattern scanner
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int PATTERN_LENGTH = 180;
  localparam int COUNTER_WIDTH  = 16;
  localparam int SAMPLE_WIDTH   = 12;

  localparam int IDX_W     = $clog2(PATTERN_LENGTH);
  localparam int LED_W     = 16;
  localparam int WIDX_W    = 8;
  localparam int OUT_W     = 16;
  localparam int CFG_IDX_W = 1;

  // count / PATTERN_LENGTH as a multiply by a rounded-up reciprocal
  localparam int RECIP_SHIFT = COUNTER_WIDTH + IDX_W;
  localparam int RECIP_W     = COUNTER_WIDTH + 1;
  localparam longint RECIP_MUL =
    ((64'd1 << RECIP_SHIFT) + PATTERN_LENGTH - 1) / PATTERN_LENGTH;
  localparam int PROD_W = COUNTER_WIDTH + RECIP_W;

  localparam logic [SAMPLE_WIDTH-1:0] LOW_THRESHOLD_RST  = SAMPLE_WIDTH'(1365);
  localparam logic [SAMPLE_WIDTH-1:0] HIGH_THRESHOLD_RST = SAMPLE_WIDTH'(1870);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_WRITE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THRESHOLD  = 1'd0,
    CFG_HIGH_THRESHOLD = 1'd1
  } cfg_idx_t;

endpackage : pls_pkg
`default_nettype wire

[rtl/pls_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 180
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read-first; data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : pls_ram
`default_nettype wire

[rtl/pov_lap_sync_pattern_scanner.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pov_lap_sync_pattern_scanner
// persistence-of-vision lap synchronizer with pattern store lookup
// ----------------------------------------------------------------------------
// Every input word (tick, sensor sample or pattern write) yields exactly one
// output word carrying the pattern entry selected after that word's update.
// A new word is taken every cycle as long as the output side drains; the
// pattern store is a ram with a registered read, so each result passes the
// read stage and then waits in the output register. The count/slot quotient
// is kept incrementally (quotient mod pattern length plus remainder), so no
// divider sits in the path; the lap close uses one multiply by a constant
// reciprocal for count / pattern length. Thresholds may be written at any
// idle time over the cfg channel, which is always ready. Pattern entries
// must be written before they are selected; an unwritten entry reads as
// garbage.
// ----------------------------------------------------------------------------
module pov_lap_sync_pattern_scanner (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // s_tdata: sample_value[11:0], write_index[19:12], write_word[35:20], zero pad
  input  wire logic [39:0]                     s_tdata,
  // s_tuser: op[1:0]
  input  wire logic [1:0]                      s_tuser,
  // output stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // m_tdata: led_word[15:0], pattern_index[23:16], lap_ticks[39:24],
  //          slot_ticks[55:40]
  output logic [55:0]                          m_tdata,
  // m_tuser: lap_done[0]
  output logic                                 m_tuser,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pls_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pls_pkg::SAMPLE_WIDTH-1:0] cfg_data
);

  import pls_pkg::*;

  // threshold registers
  logic [SAMPLE_WIDTH-1:0] low_threshold;
  logic [SAMPLE_WIDTH-1:0] high_threshold;

  // lap state
  logic [COUNTER_WIDTH-1:0] lap_counter, lap_counter_next;
  logic                     armed, armed_next;
  logic [COUNTER_WIDTH-1:0] slot_length, slot_length_next;
  logic [IDX_W-1:0]         lap_offset, lap_offset_next;
  logic [COUNTER_WIDTH-1:0] last_lap_ticks, last_lap_ticks_next;
  // lap_counter = quotient * slot_length + slot_rem, slot_quot = quotient mod length
  logic [IDX_W-1:0]         slot_quot, slot_quot_next;
  logic [COUNTER_WIDTH-1:0] slot_rem, slot_rem_next;

  // word fields
  op_t                      op;
  logic [SAMPLE_WIDTH-1:0]  sample_value;
  logic [WIDX_W-1:0]        write_index;
  logic [LED_W-1:0]         write_word;

  logic                     in_fire, out_free;
  logic                     lap_close;
  logic                     arm_now;
  logic                     wr_en;
  logic [IDX_W:0]           sel_sum;
  logic [IDX_W-1:0]         sel;
  logic [PROD_W-1:0]        lap_prod;
  logic [COUNTER_WIDTH-1:0] lap_quot;

  // ram read stage
  logic                     pend;
  logic                     pend_fwd;
  logic [LED_W-1:0]         pend_word;
  logic [IDX_W-1:0]         pend_index;
  logic                     pend_lap;
  logic [LED_W-1:0]         ram_rdata;

  assign op           = op_t'(s_tuser);
  assign sample_value = s_tdata[11:0];
  assign write_index  = s_tdata[19:12];
  assign write_word   = s_tdata[35:20];

  // the output register takes the pending result when empty or drained
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !pend || out_free;
  assign in_fire  = s_tvalid && s_tready;

  // configuration: always ready; the user must write it only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= LOW_THRESHOLD_RST;
      high_threshold <= HIGH_THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
        CFG_HIGH_THRESHOLD: high_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // count / PATTERN_LENGTH by reciprocal multiply
  assign lap_prod = PROD_W'(lap_counter) * PROD_W'(RECIP_MUL);
  assign lap_quot = COUNTER_WIDTH'(lap_prod >> RECIP_SHIFT);

  // hysteresis: arming is tested before closing
  assign arm_now   = (op == OP_SAMPLE) && !armed && (sample_value < low_threshold);
  assign lap_close = (op == OP_SAMPLE) && (armed || arm_now)
                     && (sample_value > high_threshold);

  assign wr_en = in_fire && (op == OP_WRITE)
                 && ({1'b0, write_index} < (WIDX_W + 1)'(PATTERN_LENGTH));

  always_comb begin
    lap_counter_next    = lap_counter;
    armed_next          = armed;
    slot_length_next    = slot_length;
    lap_offset_next     = lap_offset;
    last_lap_ticks_next = last_lap_ticks;
    slot_quot_next      = slot_quot;
    slot_rem_next       = slot_rem;
    case (op)
      OP_TICK: begin
        lap_counter_next = lap_counter + COUNTER_WIDTH'(1);
        if (lap_counter == {COUNTER_WIDTH{1'b1}}) begin
          // counter wraps to zero
          slot_quot_next = '0;
          slot_rem_next  = '0;
        end else if (slot_rem + COUNTER_WIDTH'(1) == slot_length) begin
          slot_rem_next  = '0;
          slot_quot_next = (slot_quot == IDX_W'(PATTERN_LENGTH - 1))
                           ? '0 : slot_quot + IDX_W'(1);
        end else begin
          slot_rem_next = slot_rem + COUNTER_WIDTH'(1);
        end
      end
      OP_SAMPLE: begin
        if (arm_now) begin
          armed_next = 1'b1;
        end
        if (lap_close) begin
          last_lap_ticks_next = lap_counter;
          lap_counter_next    = '0;
          slot_length_next    = (lap_quot == '0) ? COUNTER_WIDTH'(1) : lap_quot;
          armed_next          = 1'b0;
          lap_offset_next     = (lap_offset == IDX_W'(PATTERN_LENGTH - 1))
                                ? '0 : lap_offset + IDX_W'(1);
          slot_quot_next      = '0;
          slot_rem_next       = '0;
        end
      end
      default: ;
    endcase
  end

  // selected entry after this word's update
  assign sel_sum = {1'b0, slot_quot_next} + {1'b0, lap_offset_next};
  assign sel     = (sel_sum >= (IDX_W + 1)'(PATTERN_LENGTH))
                   ? IDX_W'(sel_sum - (IDX_W + 1)'(PATTERN_LENGTH))
                   : sel_sum[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      lap_counter    <= '0;
      armed          <= 1'b0;
      slot_length    <= COUNTER_WIDTH'(1);
      lap_offset     <= '0;
      last_lap_ticks <= '0;
      slot_quot      <= '0;
      slot_rem       <= '0;
    end else if (in_fire) begin
      lap_counter    <= lap_counter_next;
      armed          <= armed_next;
      slot_length    <= slot_length_next;
      lap_offset     <= lap_offset_next;
      last_lap_ticks <= last_lap_ticks_next;
      slot_quot      <= slot_quot_next;
      slot_rem       <= slot_rem_next;
    end
  end

  // pattern store: write and read issued on the same accept
  pls_ram #(
    .WIDTH (LED_W),
    .DEPTH (PATTERN_LENGTH)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (write_index[IDX_W-1:0]),
    .wdata (write_word),
    .re    (in_fire),
    .raddr (sel),
    .rdata (ram_rdata)
  );

  // read stage; ram read is read-first so a same-entry write is forwarded
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (in_fire) begin
      pend <= 1'b1;
    end else if (out_free) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_fwd   <= wr_en && (write_index[IDX_W-1:0] == sel);
      pend_word  <= write_word;
      pend_index <= sel;
      pend_lap   <= lap_close;
    end
  end

  // output register; lap state regs still hold the pending word's values
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (pend && out_free) begin
      m_tdata[15:0]  <= pend_fwd ? pend_word : ram_rdata;
      m_tdata[23:16] <= WIDX_W'(pend_index);
      m_tdata[39:24] <= OUT_W'(last_lap_ticks);
      m_tdata[55:40] <= OUT_W'(slot_length);
      m_tuser        <= pend_lap;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_slot_nonzero : assert property (@(posedge clk) disable iff (rst)
    slot_length != '0)
    else $error("slot length reached zero");

  a_rem_below_slot : assert property (@(posedge clk) disable iff (rst)
    slot_rem < slot_length)
    else $error("slot remainder not below slot length");

  a_index_range : assert property (@(posedge clk) disable iff (rst)
    (slot_quot < IDX_W'(PATTERN_LENGTH)) && (lap_offset < IDX_W'(PATTERN_LENGTH)))
    else $error("slot quotient or lap offset out of range");

  a_pend_after_accept : assert property (@(posedge clk) disable iff (rst)
    in_fire |=> pend)
    else $error("accepted word did not reach the read stage");

  a_lap_clears_count : assert property (@(posedge clk) disable iff (rst)
    (in_fire && lap_close) |=> (lap_counter == '0) && (slot_rem == '0))
    else $error("lap close did not clear the count");

endmodule : pov_lap_sync_pattern_scanner
`default_nettype wire

[tb/pov_lap_sync_pattern_scanner_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pov_lap_sync_pattern_scanner_checker
// watches the input, output and cfg channels of the lap scanner, predicts
// every output word from the accepted input words and compares field by field
// ----------------------------------------------------------------------------
module pov_lap_sync_pattern_scanner_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  input  wire logic                             s_tready,
  input  wire logic [39:0]                      s_tdata,
  input  wire logic [1:0]                       s_tuser,
  input  wire logic                             m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic [55:0]                      m_tdata,
  input  wire logic                             m_tuser,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [pls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pls_pkg::SAMPLE_WIDTH-1:0] cfg_data,
  output int                                    mismatches,
  output int                                    outstanding
);

  import pls_pkg::*;

  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [LED_W-1:0]  led;
    logic [IDX_W-1:0]  pidx;
    logic              done;
    logic [OUT_W-1:0]  ticks;
    logic [OUT_W-1:0]  slot;
  } scan_word_t;

  // shadow of the scanner state
  logic [SAMPLE_WIDTH-1:0]  low_thr;
  logic [SAMPLE_WIDTH-1:0]  high_thr;
  logic [COUNTER_WIDTH-1:0] lap_count;
  logic                     armed;
  logic [COUNTER_WIDTH-1:0] slot_len;
  logic [IDX_W-1:0]         lap_offset;
  logic [COUNTER_WIDTH-1:0] last_lap;
  logic [LED_W-1:0]         led_table [0:PATTERN_LENGTH-1];

  scan_word_t scan_words_due [$];
  scan_word_t want;
  int         err_total = 0;

  task automatic check_field(input string field, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      err_total++;
      if (err_total <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    end
  endtask

  task automatic predict_scan_word(input op_t op, input logic [39:0] d);
    logic [SAMPLE_WIDTH-1:0] smp;
    logic [WIDX_W-1:0]       widx;
    int unsigned             q;
    int unsigned             sel;
    scan_word_t              w;
    smp    = d[11:0];
    widx   = d[19:12];
    w.done = 1'b0;
    case (op)
      OP_TICK: lap_count = lap_count + 1'b1;
      OP_SAMPLE: begin
        // arming is tested before closing, so one sample may do both
        if (!armed && smp < low_thr) armed = 1'b1;
        if (armed && smp > high_thr) begin
          q          = 32'(lap_count) / PATTERN_LENGTH;
          last_lap   = lap_count;
          slot_len   = (q == 0) ? COUNTER_WIDTH'(1) : COUNTER_WIDTH'(q);
          lap_count  = '0;
          armed      = 1'b0;
          lap_offset = IDX_W'((32'(lap_offset) + 1) % PATTERN_LENGTH);
          w.done     = 1'b1;
        end
      end
      OP_WRITE: if (32'(widx) < PATTERN_LENGTH) led_table[widx] = d[35:20];
      default: ;
    endcase
    sel     = (32'(lap_count) / 32'(slot_len) + 32'(lap_offset)) % PATTERN_LENGTH;
    w.pidx  = IDX_W'(sel);
    w.led   = led_table[sel];
    w.ticks = last_lap;
    w.slot  = slot_len;
    scan_words_due.push_back(w);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      low_thr    = LOW_THRESHOLD_RST;
      high_thr   = HIGH_THRESHOLD_RST;
      lap_count  = '0;
      armed      = 1'b0;
      slot_len   = COUNTER_WIDTH'(1);
      lap_offset = '0;
      last_lap   = '0;
      scan_words_due.delete();
    end else begin
      // compare first: a word leaving now belongs to an earlier input
      if (m_tvalid && m_tready) begin
        if (scan_words_due.size() == 0) begin
          err_total++;
          if (err_total <= MAX_REPORTS)
            $display("%0t: unexpected word, expected none, actual %h/%b",
                     $time, m_tdata, m_tuser);
        end else begin
          want = scan_words_due.pop_front();
          check_field("led_word", want.led, m_tdata[15:0]);
          check_field("pattern_index", 16'(want.pidx), 16'(m_tdata[23:16]));
          check_field("lap_done", 16'(want.done), 16'(m_tuser));
          check_field("lap_ticks", want.ticks, m_tdata[39:24]);
          check_field("slot_ticks", want.slot, m_tdata[55:40]);
        end
      end
      if (s_tvalid && s_tready) predict_scan_word(op_t'(s_tuser), s_tdata);
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LOW_THRESHOLD:  low_thr  = cfg_data;
          CFG_HIGH_THRESHOLD: high_thr = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= scan_words_due.size();
    mismatches  <= err_total;
  end

endmodule

[tb/pov_lap_sync_pattern_scanner_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pov_lap_sync_pattern_scanner_tb
// drives ticks, sensor samples and pattern writes into the lap scanner under
// several threshold settings, with random gaps on both stream sides; the
// checker beside the block predicts and compares every output word
// ----------------------------------------------------------------------------
module pov_lap_sync_pattern_scanner_tb;
  import pls_pkg::*;

  localparam int LIMIT        = 250000;  // cycles before the run is declared hung
  localparam int RANDOM_WORDS = 996;
  localparam int PHASES       = 6;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic [39:0]             s_tdata   = '0;
  logic [1:0]              s_tuser   = OP_TICK;
  logic                    m_tready  = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_LOW_THRESHOLD;
  logic [SAMPLE_WIDTH-1:0] cfg_data  = '0;

  wire logic        s_tready;
  wire logic        m_tvalid;
  wire logic [55:0] m_tdata;
  wire logic        m_tuser;
  wire logic        cfg_ready;

  int errors;
  int waiting;

  // test-side copy of the thresholds, used to aim arm and close samples
  logic [SAMPLE_WIDTH-1:0] lo_thr = LOW_THRESHOLD_RST;
  logic [SAMPLE_WIDTH-1:0] hi_thr = HIGH_THRESHOLD_RST;

  bit tx_burst   = 1'b0;  // sender stretch without gaps
  bit rx_burst   = 1'b0;  // receiver stretch without stalls
  bit force_fast = 1'b0;  // both sides at full rate for long tick runs
  int words_sent = 0;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pov_lap_sync_pattern_scanner DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pov_lap_sync_pattern_scanner_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (errors),
    .outstanding (waiting)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stall before each output word, with stall-free stretches
  initial begin : receiver
    int unsigned gap;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      gap = (rx_burst || force_fast) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // one input word, after a random gap; valid stays high into the next word
  // when that one comes without a gap
  task automatic send_word(input op_t op, input logic [11:0] smp,
                           input logic [7:0] widx, input logic [15:0] wword);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = (tx_burst || force_fast) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, wword, widx, smp};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // unused fields carry random bits, the block must ignore them
  task automatic send_tick();
    send_word(OP_TICK, 12'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic send_sample(input logic [11:0] v);
    send_word(OP_SAMPLE, v, 8'($urandom), 16'($urandom));
  endtask

  task automatic send_write(input logic [7:0] idx, input logic [15:0] w);
    send_word(OP_WRITE, 12'($urandom), idx, w);
  endtask

  task automatic send_unused_op();
    send_word(OP_NONE, 12'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // stray traffic: pattern writes (in range or not), unused ops, any sample
  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_write(8'($urandom), 16'($urandom));
      1: send_unused_op();
      default: send_sample(12'($urandom));
    endcase
  endtask

  // drop valid and wait until every output word has been taken
  task automatic settle();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [11:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_LOW_THRESHOLD) lo_thr = val;
    else hi_thr = val;
  endtask

  // mostly well-formed laps (ticks, arm, ticks, close) with noise mixed in;
  // some laps run long so the slot length grows past one; the phase stops
  // at its word budget, even in the middle of a lap
  task automatic run_laps(input int target);
    int stop_at;
    int n_pre;
    int n_mid;
    bit broken;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      n_pre  = ($urandom_range(0, 9) == 0) ? $urandom_range(360, 800)
                                           : $urandom_range(0, 40);
      n_mid  = $urandom_range(0, 20);
      broken = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < n_pre && words_sent < stop_at; i++) begin
        if ($urandom_range(0, 7) == 0) send_noise();
        else send_tick();
      end
      if (words_sent < stop_at && !(broken && $urandom_range(0, 1) == 0))
        send_sample((lo_thr > 0) ? 12'($urandom_range(0, lo_thr - 1)) : 12'($urandom));
      for (int i = 0; i < n_mid && words_sent < stop_at; i++) send_tick();
      if (words_sent < stop_at && !(broken && $urandom_range(0, 1) == 0))
        send_sample((hi_thr < 4095) ? 12'($urandom_range(hi_thr + 1, 4095))
                                    : 12'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [11:0] lo_set [PHASES];
    logic [11:0] hi_set [PHASES];
    logic [11:0] a;
    logic [11:0] b;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // fill the whole pattern store, entry zero first since it is the one
    // selected right after reset
    for (int i = 0; i < PATTERN_LENGTH; i++) send_write(8'(i), 16'($urandom));

    // directed: unused op, ignored writes, word extremes, threshold edges
    send_unused_op();
    send_write(8'd255, 16'($urandom));
    send_write(8'(PATTERN_LENGTH), 16'($urandom));
    send_write(8'(PATTERN_LENGTH - 1), 16'hFFFF);
    send_write(8'd0, 16'h0000);
    send_sample(LOW_THRESHOLD_RST);              // at the low level: no arm
    send_sample(12'(LOW_THRESHOLD_RST - 1));     // arms
    send_sample(HIGH_THRESHOLD_RST);             // at the high level: no close
    send_sample(12'(HIGH_THRESHOLD_RST + 1));    // closes a short lap
    repeat (5) send_tick();
    send_sample(12'd0);
    send_unused_op();
    send_tick();
    send_sample(12'hFFF);
    send_sample(12'hFFF);                  // not armed, no close

    // laps at full rate: one long enough for a slot of two ticks, then
    // ticks under that slot, then a short lap back to a slot of one
    force_fast = 1'b1;
    send_sample(12'd0);
    repeat (400) send_tick();
    send_sample(12'hFFF);
    repeat (50) send_tick();
    send_sample(12'd0);
    send_sample(12'hFFF);
    force_fast = 1'b0;

    // overlapping thresholds: one sample arms and closes
    write_reg(CFG_LOW_THRESHOLD, 12'd2000);
    write_reg(CFG_HIGH_THRESHOLD, 12'd1000);
    send_tick();
    send_sample(12'd1500);
    send_sample(12'd1500);

    // random phases over several threshold settings, extremes included
    a = 12'($urandom);
    b = 12'($urandom);
    lo_set = '{12'd0,    12'hFFF, 12'd2048, 12'd1,    (a < b) ? a : b,   LOW_THRESHOLD_RST};
    hi_set = '{12'hFFF,  12'd0,   12'd2048, 12'hFFE,  (a < b) ? b : a,   HIGH_THRESHOLD_RST};
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_LOW_THRESHOLD, lo_set[p]);
      write_reg(CFG_HIGH_THRESHOLD, hi_set[p]);
      run_laps(RANDOM_WORDS / PHASES);
    end

    // drain and let the pipeline run empty
    settle();
    repeat (20) @(posedge clk);

    if (errors == 0 && waiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
